// File: design/srt_pkg.sv
// Shared types and constants for the sorted record table.
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

  localparam int unsigned REQ_W     = 2;
  localparam int unsigned KEY_W     = 32;
  localparam int unsigned SCORE_W   = 32;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned REMOVED_W = 5;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_READ   = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 3'd0,
    ST_FULL     = 3'd1,
    ST_DELETED  = 3'd2,
    ST_RECORD   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_t;

  typedef struct packed {
    logic                 latch;
    logic                 mem_we;
    logic                 wr_new;
    logic                 out_load;
    logic                 out_rec;
    status_t              out_status;
    logic [REMOVED_W-1:0] out_removed;
    logic                 out_last;
  } cmd_t;

  typedef struct packed {
    logic key_less;
    logic key_eq;
    logic out_busy;
  } stat_t;

endpackage

`default_nettype wire

// File: design/srt_req_if.sv
// Request channel: request type, key and score with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface srt_req_if;
  logic                                valid;
  logic                                ready;
  logic [srt_pkg::REQ_W-1:0]           req_type;
  logic signed [srt_pkg::KEY_W-1:0]    key;
  logic signed [srt_pkg::SCORE_W-1:0]  score;

  modport source (output valid, output req_type, output key, output score, input ready);
  modport sink   (input valid, input req_type, input key, input score, output ready);
endinterface

`default_nettype wire

// File: design/srt_res_if.sv
// Result channel: status, record and removed count with valid/ready.
`timescale 1ns / 1ps
`default_nettype none

interface srt_res_if;
  logic                                 valid;
  logic                                 ready;
  logic [srt_pkg::STATUS_W-1:0]         status;
  logic signed [srt_pkg::KEY_W-1:0]     rec_key;
  logic signed [srt_pkg::SCORE_W-1:0]   rec_score;
  logic [srt_pkg::REMOVED_W-1:0]        removed_count;
  logic                                 last;

  modport source (output valid, output status, output rec_key, output rec_score,
                  output removed_count, output last, input ready);
  modport sink   (input valid, input status, input rec_key, input rec_score,
                  input removed_count, input last, output ready);
endinterface

`default_nettype wire

// File: design/srt_datapath.sv
// Record memory, request registers, key compare and result register.
`timescale 1ns / 1ps
`default_nettype none

module srt_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  srt_pkg::cmd_t                        cmd,
  input  wire [$clog2(CAPACITY)-1:0]           rd_addr,
  input  wire [$clog2(CAPACITY)-1:0]           wr_addr,
  input  wire signed [srt_pkg::KEY_W-1:0]      in_key,
  input  wire signed [srt_pkg::SCORE_W-1:0]    in_score,
  input  wire                                  out_ready,
  output srt_pkg::stat_t                       stat,
  output logic                                 out_valid,
  output logic [srt_pkg::STATUS_W-1:0]         out_status,
  output logic signed [srt_pkg::KEY_W-1:0]     out_rec_key,
  output logic signed [srt_pkg::SCORE_W-1:0]   out_rec_score,
  output logic [srt_pkg::REMOVED_W-1:0]        out_removed_count,
  output logic                                 out_last
);

  logic signed [srt_pkg::KEY_W-1:0]   key_mem   [CAPACITY];
  logic signed [srt_pkg::SCORE_W-1:0] score_mem [CAPACITY];

  logic signed [srt_pkg::KEY_W-1:0]   req_key_r;
  logic signed [srt_pkg::SCORE_W-1:0] req_score_r;
  logic signed [srt_pkg::KEY_W-1:0]   rd_key_r;
  logic signed [srt_pkg::SCORE_W-1:0] rd_score_r;

  logic                                out_valid_r;
  logic [srt_pkg::STATUS_W-1:0]        out_status_r;
  logic signed [srt_pkg::KEY_W-1:0]    out_key_r;
  logic signed [srt_pkg::SCORE_W-1:0]  out_score_r;
  logic [srt_pkg::REMOVED_W-1:0]       out_removed_r;
  logic                                out_last_r;

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      key_mem[wr_addr]   <= cmd.wr_new ? req_key_r   : rd_key_r;
      score_mem[wr_addr] <= cmd.wr_new ? req_score_r : rd_score_r;
    end
    rd_key_r   <= key_mem[rd_addr];
    rd_score_r <= score_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_key_r   <= in_key;
      req_score_r <= in_score;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r  <= cmd.out_status;
      out_key_r     <= cmd.out_rec ? rd_key_r   : '0;
      out_score_r   <= cmd.out_rec ? rd_score_r : '0;
      out_removed_r <= cmd.out_removed;
      out_last_r    <= cmd.out_last;
    end
  end

  assign stat.key_less = rd_key_r < req_key_r;
  assign stat.key_eq   = rd_key_r == req_key_r;
  assign stat.out_busy = out_valid_r;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_rec_key       = out_key_r;
  assign out_rec_score     = out_score_r;
  assign out_removed_count = out_removed_r;
  assign out_last          = out_last_r;

endmodule

`default_nettype wire

// File: design/srt_ctrl.sv
// Sequencer for insert shift, delete compaction and read-out walk.
`timescale 1ns / 1ps
`default_nettype none

module srt_ctrl #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                in_valid,
  input  wire [srt_pkg::REQ_W-1:0]           in_req_type,
  input  wire                                out_ready,
  input  srt_pkg::stat_t                     stat,
  output logic                               in_ready,
  output srt_pkg::cmd_t                      cmd,
  output logic [$clog2(CAPACITY)-1:0]        rd_addr,
  output logic [$clog2(CAPACITY)-1:0]        wr_addr
);

  localparam int unsigned IDXW = $clog2(CAPACITY);
  localparam int unsigned CNTW = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_RD,
    S_INS_EV,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_EV,
    S_RO_RD,
    S_RO_EV,
    S_RESP
  } state_t;

  state_t                         state_r, state_nxt;
  logic [CNTW-1:0]                fill_r, fill_nxt;
  logic [IDXW-1:0]                idx_r, idx_nxt;
  logic [CNTW-1:0]                wcnt_r, wcnt_nxt;
  srt_pkg::status_t               resp_status_r, resp_status_nxt;
  logic [srt_pkg::REMOVED_W-1:0]  resp_removed_r, resp_removed_nxt;

  logic [IDXW-1:0]                last_idx;
  logic [CNTW-1:0]                w_new;
  logic                           out_free;

  assign last_idx = IDXW'(fill_r - CNTW'(1));
  assign w_new    = wcnt_r + CNTW'(!stat.key_eq);
  assign out_free = !stat.out_busy || out_ready;
  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt        = state_r;
    fill_nxt         = fill_r;
    idx_nxt          = idx_r;
    wcnt_nxt         = wcnt_r;
    resp_status_nxt  = resp_status_r;
    resp_removed_nxt = resp_removed_r;
    cmd              = '0;
    rd_addr          = idx_r;
    wr_addr          = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch        = 1'b1;
          resp_removed_nxt = '0;
          case (srt_pkg::req_t'(in_req_type))
            srt_pkg::REQ_INSERT: begin
              if (fill_r == CNTW'(CAPACITY)) begin
                resp_status_nxt = srt_pkg::ST_FULL;
                state_nxt       = S_RESP;
              end else if (fill_r == '0) begin
                idx_nxt   = '0;
                state_nxt = S_INS_PUT;
              end else begin
                idx_nxt   = last_idx;
                state_nxt = S_INS_RD;
              end
            end
            srt_pkg::REQ_DELETE: begin
              resp_status_nxt = srt_pkg::ST_DELETED;
              idx_nxt         = '0;
              wcnt_nxt        = '0;
              state_nxt       = (fill_r == '0) ? S_RESP : S_DEL_RD;
            end
            srt_pkg::REQ_READ: begin
              resp_status_nxt = srt_pkg::ST_EMPTY;
              idx_nxt         = '0;
              state_nxt       = (fill_r == '0) ? S_RESP : S_RO_RD;
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INS_RD: begin
        state_nxt = S_INS_EV;
      end
      S_INS_EV: begin
        if (stat.key_less) begin
          idx_nxt   = IDXW'(idx_r + 1'b1);
          state_nxt = S_INS_PUT;
        end else begin
          cmd.mem_we = 1'b1;
          wr_addr    = IDXW'(idx_r + 1'b1);
          if (idx_r == '0) begin
            state_nxt = S_INS_PUT;
          end else begin
            idx_nxt   = IDXW'(idx_r - 1'b1);
            state_nxt = S_INS_RD;
          end
        end
      end
      S_INS_PUT: begin
        cmd.mem_we      = 1'b1;
        cmd.wr_new      = 1'b1;
        wr_addr         = idx_r;
        fill_nxt        = fill_r + CNTW'(1);
        resp_status_nxt = srt_pkg::ST_INSERTED;
        state_nxt       = S_RESP;
      end
      S_DEL_RD: begin
        state_nxt = S_DEL_EV;
      end
      S_DEL_EV: begin
        if (!stat.key_eq) begin
          cmd.mem_we = 1'b1;
          wr_addr    = wcnt_r[IDXW-1:0];
        end
        wcnt_nxt = w_new;
        if (idx_r == last_idx) begin
          fill_nxt         = w_new;
          resp_removed_nxt = srt_pkg::REMOVED_W'(fill_r - w_new);
          state_nxt        = S_RESP;
        end else begin
          idx_nxt   = IDXW'(idx_r + 1'b1);
          state_nxt = S_DEL_RD;
        end
      end
      S_RO_RD: begin
        state_nxt = S_RO_EV;
      end
      S_RO_EV: begin
        if (out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_rec    = 1'b1;
          cmd.out_status = srt_pkg::ST_RECORD;
          cmd.out_last   = (idx_r == last_idx);
          if (idx_r == last_idx) begin
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = IDXW'(idx_r + 1'b1);
            state_nxt = S_RO_RD;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          cmd.out_load    = 1'b1;
          cmd.out_status  = resp_status_r;
          cmd.out_removed = resp_removed_r;
          cmd.out_last    = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      fill_r         <= '0;
      idx_r          <= '0;
      wcnt_r         <= '0;
      resp_status_r  <= srt_pkg::ST_INSERTED;
      resp_removed_r <= '0;
    end else begin
      state_r        <= state_nxt;
      fill_r         <= fill_nxt;
      idx_r          <= idx_nxt;
      wcnt_r         <= wcnt_nxt;
      resp_status_r  <= resp_status_nxt;
      resp_removed_r <= resp_removed_nxt;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= CNTW'(CAPACITY))
    else $error("record count above capacity");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!stat.out_busy || out_ready))
    else $error("result register overwritten while held");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mem_we |-> (CNTW'(wr_addr) <= fill_r))
    else $error("memory write beyond filled region");

  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && (in_req_type != srt_pkg::REQ_NONE)) |=> !in_ready)
    else $error("new request taken while one is in progress");

endmodule

`default_nettype wire

// File: design/sorted_record_table.sv
// Top level of the sorted record table: channel wiring of sequencer and datapath.
//
// Keeps up to CAPACITY records (signed key, signed score) in ascending key order.
// in_req carries one request per valid/ready handshake: insert, delete all
// records with a key, or read out the whole table; request type 3 is taken and
// dropped. out_res returns results on valid/ready with last set on the final
// result of each request.
// Steps of each request, with n records held:
//   insert: reads from the last record down, shifting each record at or above
//   the new key up one slot, then writes the new record (FULL status when full);
//   delete: reads every held record and compacts those with another key;
//   read-out: returns each record in key order (EMPTY status when empty).
// Every step is bound by the single read port and registered read of the record
// memory, so one request is worked at a time.
// The result register lets a new request be taken while a result still waits.
// When out_res.ready is low the sequencer holds at the next result and stalls.
// Synchronous reset empties the table at once; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module sorted_record_table #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire        clk,
  input  wire        rst_n,
  srt_req_if.sink    in_req,
  srt_res_if.source  out_res
);

  localparam int unsigned IDXW = $clog2(CAPACITY);

  srt_pkg::cmd_t    cmd;
  srt_pkg::stat_t   stat;
  logic [IDXW-1:0]  rd_addr;
  logic [IDXW-1:0]  wr_addr;

  srt_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_req.valid),
    .in_req_type (in_req.req_type),
    .out_ready   (out_res.ready),
    .stat        (stat),
    .in_ready    (in_req.ready),
    .cmd         (cmd),
    .rd_addr     (rd_addr),
    .wr_addr     (wr_addr)
  );

  srt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .rd_addr           (rd_addr),
    .wr_addr           (wr_addr),
    .in_key            (in_req.key),
    .in_score          (in_req.score),
    .out_ready         (out_res.ready),
    .stat              (stat),
    .out_valid         (out_res.valid),
    .out_status        (out_res.status),
    .out_rec_key       (out_res.rec_key),
    .out_rec_score     (out_res.rec_score),
    .out_removed_count (out_res.removed_count),
    .out_last          (out_res.last)
  );

endmodule

`default_nettype wire
